// ----- rtl/slfr_pkg.sv -----
// Shared types and constants for the sync/length frame receiver.
`timescale 1ns / 1ps
`default_nettype none
package slfr_pkg;

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int POS_W   = 6;

  // Frame header layout: sync, sync, length
  localparam int HDR_LEN = 3;
  localparam int LEN_POS = 2;

  // Register port
  localparam int APB_DW      = 32;
  localparam int APB_AW      = 3;
  localparam int REG_IDX_LSB = 2;

  localparam logic REG_SYNC_FIRST  = 1'b0;
  localparam logic REG_SYNC_SECOND = 1'b1;

  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hA5;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h5A;

  typedef struct packed {
    logic [BYTE_W-1:0] sync_first;
    logic [BYTE_W-1:0] sync_second;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FETCH = 3'b010,
    S_SEND  = 3'b100
  } back_state_t;

endpackage
`default_nettype wire

// ----- rtl/slfr_rx_if.sv -----
// Input byte channel interface.
`timescale 1ns / 1ps
`default_nettype none
interface slfr_rx_if;
  logic                       valid;
  logic                       ready;
  logic [slfr_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ----- rtl/slfr_frame_if.sv -----
// Output frame byte channel interface.
`timescale 1ns / 1ps
`default_nettype none
interface slfr_frame_if;
  logic                        valid;
  logic                        ready;
  logic [slfr_pkg::BYTE_W-1:0] frame_byte;
  logic [slfr_pkg::POS_W-1:0]  byte_position;
  logic                        frame_last;

  modport source (output valid, output frame_byte, output byte_position,
                  output frame_last, input ready);
  modport sink   (input valid, input frame_byte, input byte_position,
                  input frame_last, output ready);
endinterface
`default_nettype wire

// ----- rtl/sync_length_frame_receiver_core.sv -----
// Sync/length frame receiver top level: register port, front, queue, store, back end.
// Input: one byte per cycle while fewer than two completed frames await emission.
// Output: each frame byte gets a registered store read (FETCH), then the transaction (SEND);
//   the first byte of a frame appears once the frame is queued and the back end has passed FETCH.
// The store is two banks, each STORE_DEPTH rounded up to a power of two, so a new frame
//   fills while the last drains.
// Reset clears fill count, queue and emitter state, and loads sync bytes 0xA5 / 0x5A;
//   store contents stay undefined, with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module sync_length_frame_receiver_core #(
  parameter int STORE_DEPTH = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  slfr_rx_if.sink                            rx,
  slfr_frame_if.source                       tx,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [slfr_pkg::APB_AW-1:0]   paddr,
  input  wire logic [slfr_pkg::APB_DW-1:0]   pwdata,
  output logic      [slfr_pkg::APB_DW-1:0]   prdata,
  output logic                               pready
);

  localparam int IW = $clog2(STORE_DEPTH);
  localparam int FW = $clog2(STORE_DEPTH + 1);

  slfr_pkg::cfg_t              cfg;
  logic                        reg_sel;
  logic                        cfg_wr;

  logic                        wr_en;
  logic [IW:0]                 wr_addr;
  logic [slfr_pkg::BYTE_W-1:0] wr_data;
  logic                        rd_en;
  logic [IW:0]                 rd_addr;
  logic [slfr_pkg::BYTE_W-1:0] rd_data;

  logic                        push;
  logic [FW-1:0]               push_count;
  logic                        q_pop;
  logic                        q_valid;
  logic [FW-1:0]               q_count;
  logic                        q_full;

  // Register port
  assign pready  = 1'b1;
  assign reg_sel = paddr[slfr_pkg::REG_IDX_LSB];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first  <= slfr_pkg::SYNC_FIRST_RST;
      cfg.sync_second <= slfr_pkg::SYNC_SECOND_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        slfr_pkg::REG_SYNC_FIRST:  cfg.sync_first  <= pwdata[slfr_pkg::BYTE_W-1:0];
        slfr_pkg::REG_SYNC_SECOND: cfg.sync_second <= pwdata[slfr_pkg::BYTE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      slfr_pkg::REG_SYNC_FIRST:  prdata = slfr_pkg::APB_DW'(cfg.sync_first);
      slfr_pkg::REG_SYNC_SECOND: prdata = slfr_pkg::APB_DW'(cfg.sync_second);
      default:                   prdata = '0;
    endcase
  end

  // Receive front
  slfr_front #(.STORE_DEPTH(STORE_DEPTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .rx         (rx),
    .q_full     (q_full),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .push       (push),
    .push_count (push_count)
  );

  // Completed-frame queue
  slfr_fifo #(.WIDTH(FW)) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_count),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_count),
    .full       (q_full)
  );

  // Two-bank frame store, each bank a power of two so the bank bit prefixes the index
  slfr_ram #(.WIDTH(slfr_pkg::BYTE_W), .DEPTH(2 * (2 ** IW))) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Emit back end
  slfr_back #(.STORE_DEPTH(STORE_DEPTH)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_count (q_count),
    .q_pop   (q_pop),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .tx      (tx)
  );

  // A completed frame never arrives while the queue is full
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("frame pushed into a full queue");

  // Every emitted byte belongs to a queued frame
  a_send_has_frame: assert property (@(posedge clk) disable iff (rst)
    tx.valid |-> q_valid)
    else $error("byte emitted with no frame queued");

  // The back end returns to idle after the final byte of a frame, so valid drops
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (tx.valid && tx.ready && tx.frame_last) |=> !tx.valid)
    else $error("output valid right after final byte");

endmodule
`default_nettype wire

// ----- rtl/slfr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module slfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/slfr_fifo.sv -----
// Two-entry descriptor queue between the receive front and the emit back end.
`timescale 1ns / 1ps
`default_nettype none
module slfr_fifo #(
  parameter int WIDTH = 7
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic                  head_valid,
  output logic      [WIDTH-1:0] head_data,
  output logic                  full
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign head_valid = (count != 2'd0);
  assign full       = (count == 2'd2);
  assign head_data  = entry[rd_ptr];

  // Store pushed descriptors
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/slfr_front.sv -----
// Receive front: checks sync bytes, tracks fill and length, writes the store.
`timescale 1ns / 1ps
`default_nettype none
module slfr_front #(
  parameter int STORE_DEPTH = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire slfr_pkg::cfg_t                    cfg,
  slfr_rx_if.sink                                rx,
  input  wire logic                              q_full,
  output logic                                   wr_en,
  output logic [$clog2(STORE_DEPTH):0]           wr_addr,
  output logic [slfr_pkg::BYTE_W-1:0]            wr_data,
  output logic                                   push,
  output logic [$clog2(STORE_DEPTH+1)-1:0]       push_count
);

  localparam int IW = $clog2(STORE_DEPTH);
  localparam int FW = $clog2(STORE_DEPTH + 1);
  localparam int CW = (FW > slfr_pkg::BYTE_W) ? FW : slfr_pkg::BYTE_W;

  logic [FW-1:0]               fill;
  logic                        bank;
  logic [slfr_pkg::BYTE_W-1:0] len_reg;

  logic [FW-1:0]               fill_inc;
  logic [slfr_pkg::BYTE_W-1:0] len_eff;
  logic                        sync_bad;
  logic                        done;
  logic                        accept;

  assign rx.ready = !q_full;
  assign accept   = rx.valid && rx.ready;

  // Classify the incoming byte
  always_comb begin
    fill_inc = fill + FW'(1);
    len_eff  = (fill == FW'(slfr_pkg::LEN_POS)) ? rx.rx_byte : len_reg;
    sync_bad = ((fill == FW'(0)) && (rx.rx_byte != cfg.sync_first)) ||
               ((fill == FW'(1)) && (rx.rx_byte != cfg.sync_second));
    done     = !sync_bad && (fill_inc >= FW'(slfr_pkg::HDR_LEN)) &&
               (CW'(len_eff) == (CW'(fill_inc) - CW'(slfr_pkg::HDR_LEN)));
  end

  // Store write into the current bank
  assign wr_en      = accept;
  assign wr_addr    = {bank, fill[IW-1:0]};
  assign wr_data    = rx.rx_byte;
  assign push       = accept && done;
  assign push_count = fill_inc;

  // Capture the length byte
  always_ff @(posedge clk) begin
    if (accept && (fill == FW'(slfr_pkg::LEN_POS))) begin
      len_reg <= rx.rx_byte;
    end
  end

  // Advance fill count; drop on sync miss or full store, swap bank on completion
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      bank <= 1'b0;
    end else if (accept) begin
      if (sync_bad || done || (fill_inc == FW'(STORE_DEPTH))) begin
        fill <= '0;
      end else begin
        fill <= fill_inc;
      end
      if (done) begin
        bank <= ~bank;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/slfr_back.sv -----
// Emit back end: reads a completed frame from the store and sends it byte by byte.
`timescale 1ns / 1ps
`default_nettype none
module slfr_back #(
  parameter int STORE_DEPTH = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              q_valid,
  input  wire logic [$clog2(STORE_DEPTH+1)-1:0]  q_count,
  output logic                                   q_pop,
  output logic                                   rd_en,
  output logic [$clog2(STORE_DEPTH):0]           rd_addr,
  input  wire logic [slfr_pkg::BYTE_W-1:0]       rd_data,
  slfr_frame_if.source                           tx
);

  localparam int IW = $clog2(STORE_DEPTH);
  localparam int FW = $clog2(STORE_DEPTH + 1);

  slfr_pkg::back_state_t state;
  logic [IW-1:0]         idx;
  logic                  bank;
  logic                  last;

  assign last             = ((FW'(idx) + FW'(1)) == q_count);
  assign tx.valid         = (state == slfr_pkg::S_SEND);
  assign tx.frame_byte    = rd_data;
  assign tx.byte_position = slfr_pkg::POS_W'(idx);
  assign tx.frame_last    = last;
  assign rd_en            = (state == slfr_pkg::S_FETCH);
  assign rd_addr          = {bank, idx};
  assign q_pop            = tx.valid && tx.ready && last;

  // Fetch one byte, then hold it until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slfr_pkg::S_IDLE;
      idx   <= '0;
      bank  <= 1'b0;
    end else begin
      case (state)
        slfr_pkg::S_IDLE: begin
          if (q_valid) begin
            state <= slfr_pkg::S_FETCH;
          end
        end
        slfr_pkg::S_FETCH: begin
          state <= slfr_pkg::S_SEND;
        end
        slfr_pkg::S_SEND: begin
          if (tx.ready) begin
            if (last) begin
              idx   <= '0;
              bank  <= ~bank;
              state <= slfr_pkg::S_IDLE;
            end else begin
              idx   <= idx + IW'(1);
              state <= slfr_pkg::S_FETCH;
            end
          end
        end
        default: begin
          state <= slfr_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- verif/tb_sync_length_frame_receiver_core.sv -----
// Self-checking testbench for the sync/length frame receiver core.
`timescale 1ns / 1ps
module tb_sync_length_frame_receiver_core;

  localparam int STORE_DEPTH   = 64;
  localparam int DRAIN_CYCLES  = 16;
  localparam int LONG_HOLD     = 400;
  localparam int WATCHDOG_MAX  = 2000;

  typedef struct packed {
    logic [slfr_pkg::BYTE_W-1:0] data;
    logic [slfr_pkg::POS_W-1:0]  pos;
    logic                        last;
  } frame_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [slfr_pkg::APB_AW-1:0] paddr;
  logic [slfr_pkg::APB_DW-1:0] pwdata;
  logic [slfr_pkg::APB_DW-1:0] prdata;
  logic                        pready;

  slfr_rx_if    rx_ch ();
  slfr_frame_if tx_ch ();

  sync_length_frame_receiver_core #(
    .STORE_DEPTH(STORE_DEPTH)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_ch),
    .tx     (tx_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #2 clk = ~clk;

  // Deframer shadow state and configuration
  slfr_pkg::cfg_t              sync_cfg;
  logic [6:0]                  frame_fill;
  logic [slfr_pkg::BYTE_W-1:0] frame_mem [STORE_DEPTH];

  // Pending input bytes and expected output bytes
  logic [slfr_pkg::BYTE_W-1:0] rx_byte_q [$];
  frame_beat_t                 frame_beat_q [$];
  frame_beat_t                 beat_exp;

  int  rx_pushed = 0;
  int  rx_taken = 0;
  int  beats_seen = 0;
  int  err_cnt = 0;
  int  idle_cycles = 0;
  int  rx_gap = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  bit  long_hold_done = 1'b0;
  bit  no_idle = 1'b0;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Advance the deframer by one received byte, queue any completed frame
  function automatic void deframe_byte(input logic [slfr_pkg::BYTE_W-1:0] b);
    frame_beat_t beat;
    int          k;
    if (frame_fill >= STORE_DEPTH) frame_fill = '0;
    frame_mem[frame_fill[5:0]] = b;
    frame_fill = frame_fill + 7'd1;
    if (frame_fill == 7'd1 && b != sync_cfg.sync_first) frame_fill = '0;
    if (frame_fill == 7'd2 && b != sync_cfg.sync_second) frame_fill = '0;
    if (frame_fill >= slfr_pkg::HDR_LEN &&
        frame_mem[slfr_pkg::LEN_POS] == 8'(frame_fill - slfr_pkg::HDR_LEN)) begin
      for (k = 0; k < frame_fill; k++) begin
        beat.data = frame_mem[k];
        beat.pos  = slfr_pkg::POS_W'(k);
        beat.last = (k + 1 == frame_fill);
        frame_beat_q.push_back(beat);
      end
      frame_fill = '0;
    end
    if (frame_fill >= STORE_DEPTH) frame_fill = '0;
  endfunction

  task automatic push_rx(input logic [slfr_pkg::BYTE_W-1:0] b);
    rx_byte_q.push_back(b);
    rx_pushed++;
  endtask

  // Queue a header with the given length byte, followed by body_cnt random payload bytes
  task automatic queue_frame(input logic [slfr_pkg::BYTE_W-1:0] len, input int body_cnt);
    int i;
    push_rx(sync_cfg.sync_first);
    push_rx(sync_cfg.sync_second);
    push_rx(len);
    for (i = 0; i < body_cnt; i++) push_rx(slfr_pkg::BYTE_W'($urandom_range(0, 255)));
  endtask

  // Register write: setup cycle, then access cycle until pready
  task automatic reg_write(input logic idx, input logic [slfr_pkg::BYTE_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= slfr_pkg::APB_AW'(idx) << slfr_pkg::REG_IDX_LSB;
    pwdata  <= slfr_pkg::APB_DW'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == slfr_pkg::REG_SYNC_FIRST) sync_cfg.sync_first = val;
    else sync_cfg.sync_second = val;
  endtask

  // Hold until every byte is taken and every frame byte is out, then let the core settle
  task automatic wait_drained();
    while (rx_taken != rx_pushed || frame_beat_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Input driver: offer pending bytes with random gaps
  always @(posedge clk) begin
    if (rst) begin
      rx_ch.valid   <= 1'b0;
      rx_ch.rx_byte <= '0;
      rx_gap = 0;
    end else if (!rx_ch.valid || rx_ch.ready) begin
      if (rx_gap > 0) begin
        rx_ch.valid <= 1'b0;
        rx_gap--;
      end else if (rx_byte_q.size() > 0) begin
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= rx_byte_q.pop_front();
        rx_gap = no_idle ? 0 : pick_gap();
      end else begin
        rx_ch.valid <= 1'b0;
      end
    end
  end

  // Output receiver: random stalls, plus one long hold-off while input is still queued
  always @(posedge clk) begin
    if (rst) begin
      tx_ch.ready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else if (hold_left > 0) begin
      tx_ch.ready <= 1'b0;
      hold_left--;
    end else if (!long_hold_done && beats_seen >= 40 && rx_byte_q.size() >= 16) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD;
      tx_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      tx_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      tx_ch.ready <= 1'b1;
      stall_left = no_idle ? 0 : pick_gap();
    end
  end

  // Monitor: check each output transaction, predict on each input transaction
  always @(posedge clk) begin
    if (!rst) begin
      if (tx_ch.valid && tx_ch.ready) begin
        if (frame_beat_q.size() == 0) begin
          $error("unexpected frame byte %0h at position %0d", tx_ch.frame_byte,
                 tx_ch.byte_position);
          err_cnt++;
        end else begin
          beat_exp = frame_beat_q.pop_front();
          if (tx_ch.frame_byte !== beat_exp.data) begin
            $error("frame_byte: expected %0h, got %0h", beat_exp.data, tx_ch.frame_byte);
            err_cnt++;
          end
          if (tx_ch.byte_position !== beat_exp.pos) begin
            $error("byte_position: expected %0d, got %0d", beat_exp.pos,
                   tx_ch.byte_position);
            err_cnt++;
          end
          if (tx_ch.frame_last !== beat_exp.last) begin
            $error("frame_last: expected %0b, got %0b", beat_exp.last, tx_ch.frame_last);
            err_cnt++;
          end
        end
        beats_seen++;
      end
      if (rx_ch.valid && rx_ch.ready) begin
        deframe_byte(rx_ch.rx_byte);
        rx_taken++;
      end
    end
  end

  // Watchdog: count cycles without any transaction
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else if ((rx_ch.valid && rx_ch.ready) || (tx_ch.valid && tx_ch.ready) ||
                 (psel && penable && pready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("watchdog: no transaction for %0d cycles", idle_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Stimulus sequence
  initial begin
    logic [slfr_pkg::BYTE_W-1:0] directed_seq [24] = '{
      slfr_pkg::SYNC_FIRST_RST, slfr_pkg::SYNC_SECOND_RST, 8'h00,
      8'h00,
      slfr_pkg::SYNC_FIRST_RST, 8'h00,
      slfr_pkg::SYNC_FIRST_RST, slfr_pkg::SYNC_FIRST_RST,
      slfr_pkg::SYNC_FIRST_RST, slfr_pkg::SYNC_SECOND_RST, 8'h01, 8'hFF,
      8'hFF,
      slfr_pkg::SYNC_FIRST_RST, slfr_pkg::SYNC_SECOND_RST, 8'h02, 8'h00, 8'hFF,
      slfr_pkg::SYNC_FIRST_RST, slfr_pkg::SYNC_SECOND_RST, 8'h03,
      slfr_pkg::SYNC_SECOND_RST, slfr_pkg::SYNC_FIRST_RST, 8'h80
    };
    logic [slfr_pkg::BYTE_W-1:0] s1;
    logic [slfr_pkg::BYTE_W-1:0] s2;
    logic [slfr_pkg::BYTE_W-1:0] len;
    int                          ph;
    int                          start;
    int                          budget;
    int                          r;

    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = '0;
    tx_ch.ready   = 1'b0;
    sync_cfg.sync_first  = slfr_pkg::SYNC_FIRST_RST;
    sync_cfg.sync_second = slfr_pkg::SYNC_SECOND_RST;
    frame_fill = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed bytes at reset sync values
    foreach (directed_seq[i]) push_rx(directed_seq[i]);
    wait_drained();

    for (ph = 1; ph <= 4; ph++) begin
      case (ph)
        1: begin
          s1 = 8'h00;
          s2 = 8'hFF;
        end
        2: begin
          s1 = 8'hFF;
          s2 = 8'h00;
        end
        3: begin
          s1 = slfr_pkg::BYTE_W'($urandom_range(0, 255));
          s2 = slfr_pkg::BYTE_W'($urandom_range(0, 255));
        end
        default: begin
          s1 = slfr_pkg::BYTE_W'($urandom_range(0, 255));
          s2 = s1;
        end
      endcase
      reg_write(slfr_pkg::REG_SYNC_FIRST, s1);
      reg_write(slfr_pkg::REG_SYNC_SECOND, s2);
      no_idle = (ph == 2);
      start  = rx_pushed;
      budget = (ph == 1 || ph == 4) ? 75 : 25;

      // Longest frame that still completes, and a length that never completes
      if (ph == 1) begin
        queue_frame(8'(STORE_DEPTH - slfr_pkg::HDR_LEN), STORE_DEPTH - slfr_pkg::HDR_LEN);
      end
      if (ph == 4) begin
        queue_frame(slfr_pkg::BYTE_W'($urandom_range(STORE_DEPTH - slfr_pkg::HDR_LEN + 1,
                                                      255)),
                    STORE_DEPTH - slfr_pkg::HDR_LEN);
      end

      while (rx_pushed - start < budget) begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          len = ($urandom_range(0, 9) == 0) ? slfr_pkg::BYTE_W'($urandom_range(8, 24))
                                            : slfr_pkg::BYTE_W'($urandom_range(0, 7));
          queue_frame(len, len);
        end else if (r < 75) begin
          // Broken header: right first sync, wrong second
          push_rx(sync_cfg.sync_first);
          push_rx(sync_cfg.sync_second ^ slfr_pkg::BYTE_W'($urandom_range(1, 255)));
        end else if (r < 85) begin
          repeat ($urandom_range(1, 3)) push_rx(slfr_pkg::BYTE_W'($urandom_range(0, 255)));
        end else if (r < 92) begin
          // Truncated frame: following bytes fold into it
          len = slfr_pkg::BYTE_W'($urandom_range(2, 8));
          queue_frame(len, $urandom_range(0, len - 1));
        end else begin
          push_rx(sync_cfg.sync_first);
          len = slfr_pkg::BYTE_W'($urandom_range(0, 5));
          queue_frame(len, len);
        end
      end
      wait_drained();
    end

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
